// File: hdl/lrwa_pkg.sv
// shared constants, types and control structs for the lattice random walk absorber
package lrwa_pkg;

	// lattice size and coordinate width
	localparam int MAX_DIMS   = 8;
	localparam int COORD_BITS = 16;

	// field widths fixed by the interface
	localparam int DIMS_W   = 4;
	localparam int MODE_W   = 2;
	localparam int BOUND_W  = 15;
	localparam int PROB_W   = 17;
	localparam int STEPS_W  = 32;
	localparam int DIR_W    = 3;
	localparam int FRAC_W   = 16;
	localparam int VALUE_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// derived widths
	localparam int AXIS_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W     = DIMS_W + 1;
	localparam int MAG_BITS  = COORD_BITS - 1;
	localparam int MUL_W     = (MAG_BITS > BOUND_W) ? MAG_BITS : BOUND_W;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int SUM_W     = PROD_W + CNT_W;

	// coordinate clamp limits, symmetric around zero
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN =
		{1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};

	// absorption modes
	typedef enum logic [MODE_W-1:0] {
		MODE_CHANCE = 2'd0,
		MODE_SQUARE = 2'd1,
		MODE_CIRCLE = 2'd2,
		MODE_NEVER  = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIMENSIONS  = 3'd0,
		REG_WELL_MODE   = 3'd1,
		REG_BOUNDARY    = 3'd2,
		REG_PROBABILITY = 3'd3,
		REG_MAX_STEPS   = 3'd4
	} cfg_idx_t;

	// operation of the shared squarer
	typedef enum logic [1:0] {
		MUL_NONE   = 2'd0,
		MUL_LIMIT  = 2'd1,
		MUL_SQUARE = 2'd2
	} mul_op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_CMD    = 3'd1,
		ST_SCAN   = 3'd2,
		ST_DRAIN  = 3'd3,
		ST_FINISH = 3'd4
	} state_t;

	// configuration registers
	typedef struct packed {
		logic [DIMS_W-1:0]  dimensions;
		mode_t              well_mode;
		logic [BOUND_W-1:0] boundary;
		logic [PROB_W-1:0]  probability;
		logic [STEPS_W-1:0] max_steps;
	} cfg_t;

	// sequencer to datapath
	typedef struct packed {
		logic    item_load;
		logic    cmd_exec;
		logic    scan_clr;
		logic    scan_step;
		logic    out_load;
		mul_op_t mul_op;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic restart;
		logic bad;
		logic use_scan;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// File: hdl/lrwa_ctrl.sv
// sequencer for command execution, axis scan and result hand-off
module lrwa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lrwa_pkg::stat_t stat,
	output lrwa_pkg::ctrl_t ctrl
);

	lrwa_pkg::state_t state_q;
	lrwa_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrwa_pkg::ST_IDLE: begin
				if (in_valid) state_d = lrwa_pkg::ST_CMD;
			end
			lrwa_pkg::ST_CMD: begin
				if (stat.restart || stat.bad || !stat.use_scan) state_d = lrwa_pkg::ST_FINISH;
				else state_d = lrwa_pkg::ST_SCAN;
			end
			lrwa_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = lrwa_pkg::ST_DRAIN;
			end
			lrwa_pkg::ST_DRAIN: begin
				state_d = lrwa_pkg::ST_FINISH;
			end
			lrwa_pkg::ST_FINISH: begin
				if (stat.out_free) state_d = lrwa_pkg::ST_IDLE;
			end
			default: begin
				state_d = lrwa_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = 1'b1;
		ctrl.item_load = 1'b0;
		ctrl.cmd_exec  = 1'b0;
		ctrl.scan_clr  = 1'b0;
		ctrl.scan_step = 1'b0;
		ctrl.out_load  = 1'b0;
		ctrl.mul_op    = lrwa_pkg::MUL_NONE;
		unique case (state_q)
			lrwa_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				ctrl.item_load = in_valid;
			end
			lrwa_pkg::ST_CMD: begin
				// boundary squared goes through the squarer while the move happens
				ctrl.cmd_exec = 1'b1;
				ctrl.scan_clr = 1'b1;
				ctrl.mul_op   = lrwa_pkg::MUL_LIMIT;
			end
			lrwa_pkg::ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				ctrl.mul_op    = lrwa_pkg::MUL_SQUARE;
			end
			lrwa_pkg::ST_DRAIN: begin
			end
			lrwa_pkg::ST_FINISH: begin
				ctrl.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/lrwa_datapath.sv
// walker state, shared squarer with accumulator, absorption test and output register
module lrwa_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrwa_pkg::cfg_t                      cfg,
	input  lrwa_pkg::ctrl_t                     ctrl,
	output lrwa_pkg::stat_t                     stat,
	input  logic                                func,
	input  logic [lrwa_pkg::DIR_W-1:0]          direction,
	input  logic                                step_up,
	input  logic [lrwa_pkg::FRAC_W-1:0]         random_fraction,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                caught,
	output logic [lrwa_pkg::STEPS_W-1:0]        step_count,
	output logic [lrwa_pkg::DIR_W-1:0]          moved_axis,
	output logic signed [lrwa_pkg::VALUE_W-1:0] moved_value,
	output logic                                bad_direction
);

	localparam int CB = lrwa_pkg::COORD_BITS;

	// latched item
	logic                         func_q;
	logic [lrwa_pkg::DIR_W-1:0]   dir_q;
	logic                         up_q;
	logic [lrwa_pkg::FRAC_W-1:0]  frac_q;

	// walker state
	logic signed [CB-1:0]         pos_q [lrwa_pkg::MAX_DIMS];
	logic [lrwa_pkg::STEPS_W-1:0] steps_q;

	// scan and squarer state
	logic [lrwa_pkg::AXIS_BITS-1:0] idx_q;
	logic [lrwa_pkg::PROD_W-1:0]    prod_q;
	lrwa_pkg::mul_op_t              tag_q;
	logic [lrwa_pkg::PROD_W-1:0]    limit_q;
	logic [lrwa_pkg::SUM_W-1:0]     sum_q;
	logic                           any_q;
	logic                           out_valid_q;

	logic [lrwa_pkg::CNT_W-1:0]                 axes_n;
	logic [lrwa_pkg::AXIS_BITS+lrwa_pkg::DIR_W-1:0] dir_ext;
	logic [lrwa_pkg::AXIS_BITS-1:0]             dir_idx;
	logic [lrwa_pkg::AXIS_BITS-1:0]             rd_idx;
	logic signed [CB-1:0]                       rd_val;
	logic signed [CB-1:0]                       neg_val;
	logic signed [CB-1:0]                       new_val;
	logic [lrwa_pkg::MAG_BITS-1:0]              mag;
	logic [lrwa_pkg::MUL_W-1:0]                 mul_a;
	logic [lrwa_pkg::PROD_W-1:0]                prod;
	logic signed [CB+lrwa_pkg::VALUE_W-1:0]     val_wide;
	logic                                       is_bad;
	logic                                       limit_hit;
	logic                                       mode_hit;
	logic                                       caught_c;

	// axes in use, clamped to the lattice size
	assign axes_n = (lrwa_pkg::CNT_W'(cfg.dimensions) > lrwa_pkg::CNT_W'(lrwa_pkg::MAX_DIMS))
		? lrwa_pkg::CNT_W'(lrwa_pkg::MAX_DIMS) : lrwa_pkg::CNT_W'(cfg.dimensions);
	assign is_bad  = lrwa_pkg::CNT_W'(dir_q) >= axes_n;
	assign dir_ext = {{lrwa_pkg::AXIS_BITS{1'b0}}, dir_q};
	assign dir_idx = dir_ext[lrwa_pkg::AXIS_BITS-1:0];

	// single read port into the coordinates
	assign rd_idx  = ctrl.scan_step ? idx_q : dir_idx;
	assign rd_val  = pos_q[rd_idx];
	assign neg_val = -rd_val;
	assign mag     = rd_val[CB-1] ? neg_val[lrwa_pkg::MAG_BITS-1:0]
		: rd_val[lrwa_pkg::MAG_BITS-1:0];

	// saturating unit move
	always_comb begin
		if (up_q) begin
			new_val = (rd_val == lrwa_pkg::COORD_MAX) ? rd_val : rd_val + CB'(1);
		end else begin
			new_val = (rd_val == lrwa_pkg::COORD_MIN) ? rd_val : rd_val - CB'(1);
		end
	end

	// shared squarer operand select
	assign mul_a = (ctrl.mul_op == lrwa_pkg::MUL_LIMIT) ? lrwa_pkg::MUL_W'(cfg.boundary)
		: lrwa_pkg::MUL_W'(mag);
	assign prod  = mul_a * mul_a;

	// item latch
	always_ff @(posedge clk) begin
		if (ctrl.item_load) begin
			func_q <= func;
			dir_q  <= direction;
			up_q   <= step_up;
			frac_q <= random_fraction;
		end
	end

	// coordinates and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrwa_pkg::MAX_DIMS; i++) pos_q[i] <= '0;
			steps_q <= '0;
		end else if (ctrl.cmd_exec) begin
			if (func_q) begin
				for (int i = 0; i < lrwa_pkg::MAX_DIMS; i++) pos_q[i] <= '0;
				steps_q <= '0;
			end else if (!is_bad) begin
				pos_q[dir_idx] <= new_val;
				if (steps_q != {lrwa_pkg::STEPS_W{1'b1}}) steps_q <= steps_q + 32'd1;
			end
		end
	end

	// squarer tag and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= lrwa_pkg::MUL_NONE;
			idx_q <= '0;
		end else begin
			tag_q <= ctrl.mul_op;
			if (ctrl.scan_clr) idx_q <= '0;
			else if (ctrl.scan_step) idx_q <= idx_q + lrwa_pkg::AXIS_BITS'(1);
		end
	end

	// product register, limit capture, sum of squares and square-well flag
	always_ff @(posedge clk) begin
		prod_q <= prod;
		case (tag_q)
			lrwa_pkg::MUL_LIMIT:  limit_q <= prod_q;
			lrwa_pkg::MUL_SQUARE: sum_q   <= sum_q + lrwa_pkg::SUM_W'(prod_q);
			default: begin
			end
		endcase
		if (ctrl.scan_clr) begin
			sum_q <= '0;
			any_q <= 1'b0;
		end else if (ctrl.scan_step) begin
			if (lrwa_pkg::MUL_W'(mag) >= lrwa_pkg::MUL_W'(cfg.boundary)) any_q <= 1'b1;
		end
	end

	// absorption decision
	assign limit_hit = (cfg.max_steps != '0) && (steps_q >= cfg.max_steps);
	always_comb begin
		case (cfg.well_mode)
			lrwa_pkg::MODE_CHANCE: mode_hit = {1'b0, frac_q} <= cfg.probability;
			lrwa_pkg::MODE_SQUARE: mode_hit = any_q;
			lrwa_pkg::MODE_CIRCLE: mode_hit = sum_q >= lrwa_pkg::SUM_W'(limit_q);
			default:               mode_hit = 1'b0;
		endcase
	end
	assign caught_c = limit_hit || mode_hit;

	// low bits of the moved coordinate, sign extended when coordinates are narrow
	assign val_wide = (CB+lrwa_pkg::VALUE_W)'(rd_val);

	// output register
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			if (func_q) begin
				caught        <= 1'b0;
				step_count    <= '0;
				moved_axis    <= '0;
				moved_value   <= '0;
				bad_direction <= 1'b0;
			end else if (is_bad) begin
				caught        <= 1'b0;
				step_count    <= steps_q;
				moved_axis    <= '0;
				moved_value   <= '0;
				bad_direction <= 1'b1;
			end else begin
				caught        <= caught_c;
				step_count    <= steps_q;
				moved_axis    <= dir_q;
				moved_value   <= val_wide[lrwa_pkg::VALUE_W-1:0];
				bad_direction <= 1'b0;
			end
		end
	end

	// output valid, cleared by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	// status to the sequencer
	assign stat.restart   = func_q;
	assign stat.bad       = is_bad;
	assign stat.use_scan  = (cfg.well_mode == lrwa_pkg::MODE_SQUARE)
		|| (cfg.well_mode == lrwa_pkg::MODE_CIRCLE);
	assign stat.scan_last = lrwa_pkg::CNT_W'(idx_q) == (axes_n - lrwa_pkg::CNT_W'(1));
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

// File: hdl/lattice_random_walk_absorber.sv
// Flow: restart, bad direction, chance and never modes go from the command state straight
// to the finish state; square and circular wells first scan the n axes in use, then drain.
// One item at a time: no new input is taken until its result is loaded into the output
// register, and the well modes visit one coordinate per cycle with the shared squarer and compare.
// Reset: asynchronous active low; walker at origin, step count zero, registers at defaults.
module lattice_random_walk_absorber (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   func,
	input  logic [lrwa_pkg::DIR_W-1:0]             direction,
	input  logic                                   step_up,
	input  logic [lrwa_pkg::FRAC_W-1:0]            random_fraction,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   caught,
	output logic [lrwa_pkg::STEPS_W-1:0]           step_count,
	output logic [lrwa_pkg::DIR_W-1:0]             moved_axis,
	output logic signed [lrwa_pkg::VALUE_W-1:0]    moved_value,
	output logic                                   bad_direction,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lrwa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lrwa_pkg::CFG_DATA_W-1:0]        cfg_data
);

	lrwa_pkg::cfg_t  cfg_q;
	lrwa_pkg::ctrl_t ctrl;
	lrwa_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers, written on a cfg transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dimensions  <= lrwa_pkg::DIMS_W'(2);
			cfg_q.well_mode   <= lrwa_pkg::MODE_CHANCE;
			cfg_q.boundary    <= '0;
			cfg_q.probability <= lrwa_pkg::PROB_W'(6554);
			cfg_q.max_steps   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrwa_pkg::REG_DIMENSIONS:
					cfg_q.dimensions <= cfg_data[lrwa_pkg::DIMS_W-1:0];
				lrwa_pkg::REG_WELL_MODE:
					cfg_q.well_mode <= lrwa_pkg::mode_t'(cfg_data[lrwa_pkg::MODE_W-1:0]);
				lrwa_pkg::REG_BOUNDARY:
					cfg_q.boundary <= cfg_data[lrwa_pkg::BOUND_W-1:0];
				lrwa_pkg::REG_PROBABILITY:
					cfg_q.probability <= cfg_data[lrwa_pkg::PROB_W-1:0];
				lrwa_pkg::REG_MAX_STEPS:
					cfg_q.max_steps <= cfg_data[lrwa_pkg::STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lrwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	lrwa_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.ctrl            (ctrl),
		.stat            (stat),
		.func            (func),
		.direction       (direction),
		.step_up         (step_up),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.caught          (caught),
		.step_count      (step_count),
		.moved_axis      (moved_axis),
		.moved_value     (moved_value),
		.bad_direction   (bad_direction)
	);

endmodule

// File: hdl/lrwa_checker.sv
// port-level checks for the lattice random walk absorber, bound to the top level
module lrwa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                caught,
	input logic [lrwa_pkg::STEPS_W-1:0]        step_count,
	input logic [lrwa_pkg::DIR_W-1:0]          moved_axis,
	input logic signed [lrwa_pkg::VALUE_W-1:0] moved_value,
	input logic                                bad_direction
);

	// one item at a time: an input transfer is followed by a busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	// an ignored step reports no move and no capture
	a_bad_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_direction |-> !caught && moved_axis == '0 && moved_value == '0)
		else $error("bad direction result carries a move or a capture");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its step count, capture flag and moved value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(step_count) && $stable(caught)
			&& $stable(moved_value))
		else $error("result payload changed while stalled");

endmodule

bind lattice_random_walk_absorber lrwa_checker u_lrwa_checker (.*);

// File: sim/lattice_random_walk_absorber_check.sv
// checker module: tracks the walker, predicts each result and compares it with the block output
`timescale 1ns / 1ps
module lattice_random_walk_absorber_check
	import lrwa_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      func,
	input  logic [DIR_W-1:0]          direction,
	input  logic                      step_up,
	input  logic [FRAC_W-1:0]         random_fraction,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      caught,
	input  logic [STEPS_W-1:0]        step_count,
	input  logic [DIR_W-1:0]          moved_axis,
	input  logic signed [VALUE_W-1:0] moved_value,
	input  logic                      bad_direction,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int unsigned               mismatches,
	output int unsigned               outstanding,
	output int unsigned               results_checked,
	output int unsigned               captures_seen,
	output int unsigned               bad_seen
);

	localparam int COORD_LIMIT = 2 ** (COORD_BITS - 1) - 1;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic                      caught;
		logic [STEPS_W-1:0]        step_count;
		logic [DIR_W-1:0]          moved_axis;
		logic signed [VALUE_W-1:0] moved_value;
		logic                      bad_direction;
	} walk_result_t;

	// shadow copy of the registers
	logic [DIMS_W-1:0]  dims_reg;
	mode_t              mode_reg;
	logic [BOUND_W-1:0] bound_reg;
	logic [PROB_W-1:0]  prob_reg;
	logic [STEPS_W-1:0] limit_reg;

	// walker position and step count
	logic signed [COORD_BITS-1:0] coord [MAX_DIMS];
	logic [STEPS_W-1:0]           steps_done;
	walk_result_t                 pending_results [$];

	// one line per mismatch, quiet after the first few
	task automatic report_mismatch(input string field, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
				$time, field, results_checked, got, want);
	endtask

	function automatic longint unsigned coord_magnitude(input logic signed [COORD_BITS-1:0] c);
		return (c < 0) ? -longint'(c) : longint'(c);
	endfunction

	// capture test on the walker after a move
	function automatic logic walker_absorbed(input logic [FRAC_W-1:0] frac,
		input int unsigned axes);
		longint unsigned sum;
		longint unsigned radius_sq;
		if (limit_reg != '0 && steps_done >= limit_reg)
			return 1'b1;
		sum = 0;
		radius_sq = longint'(bound_reg) * longint'(bound_reg);
		case (mode_reg)
			MODE_CHANCE: return frac <= prob_reg;
			MODE_SQUARE: begin
				for (int i = 0; i < axes; i++)
					if (coord_magnitude(coord[i]) >= bound_reg)
						return 1'b1;
				return 1'b0;
			end
			MODE_CIRCLE: begin
				for (int i = 0; i < axes; i++)
					sum += coord_magnitude(coord[i]) * coord_magnitude(coord[i]);
				return sum >= radius_sq;
			end
			default: return 1'b0;
		endcase
	endfunction

	// apply one input transfer to the walker and build its result
	function automatic walk_result_t advance_walker(input logic restart,
		input logic [DIR_W-1:0] dir, input logic up, input logic [FRAC_W-1:0] frac);
		walk_result_t res;
		int unsigned  axes;
		int           nxt;
		res = '0;
		axes = (dims_reg > MAX_DIMS) ? MAX_DIMS : dims_reg;
		if (restart) begin
			foreach (coord[i]) coord[i] = '0;
			steps_done = '0;
			return res;
		end
		// axis out of range: nothing moves, count reported as is
		if (dir >= axes) begin
			res.step_count = steps_done;
			res.bad_direction = 1'b1;
			return res;
		end
		nxt = up ? coord[dir] + 1 : coord[dir] - 1;
		if (nxt > COORD_LIMIT)
			nxt = COORD_LIMIT;
		if (nxt < -COORD_LIMIT)
			nxt = -COORD_LIMIT;
		coord[dir] = nxt[COORD_BITS-1:0];
		if (steps_done != '1)
			steps_done = steps_done + 1'b1;
		res.caught = walker_absorbed(frac, axes);
		res.step_count = steps_done;
		res.moved_axis = dir;
		res.moved_value = nxt[VALUE_W-1:0];
		return res;
	endfunction

	// follow all three channels
	always @(posedge clk or negedge arst_n) begin
		walk_result_t want;
		walk_result_t fresh;
		if (!arst_n) begin
			dims_reg = 4'd2;
			mode_reg = MODE_CHANCE;
			bound_reg = '0;
			prob_reg = 17'd6554;
			limit_reg = '0;
			foreach (coord[i]) coord[i] = '0;
			steps_done = '0;
			pending_results.delete();
			outstanding = 0;
		end else begin
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_DIMENSIONS:  dims_reg = cfg_data[DIMS_W-1:0];
					REG_WELL_MODE:   mode_reg = mode_t'(cfg_data[MODE_W-1:0]);
					REG_BOUNDARY:    bound_reg = cfg_data[BOUND_W-1:0];
					REG_PROBABILITY: prob_reg = cfg_data[PROB_W-1:0];
					REG_MAX_STEPS:   limit_reg = cfg_data[STEPS_W-1:0];
					default: ;
				endcase
			end
			// input transfer
			if (in_valid && !in_stall) begin
				fresh = advance_walker(func, direction, step_up, random_fraction);
				pending_results = {pending_results, fresh};
			end
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (caught !== want.caught)
						report_mismatch("caught", caught, want.caught);
					if (step_count !== want.step_count)
						report_mismatch("step_count", step_count, want.step_count);
					if (moved_axis !== want.moved_axis)
						report_mismatch("moved_axis", moved_axis, want.moved_axis);
					if (moved_value !== want.moved_value)
						report_mismatch("moved_value", moved_value, want.moved_value);
					if (bad_direction !== want.bad_direction)
						report_mismatch("bad_direction", bad_direction, want.bad_direction);
					if (want.caught)
						captures_seen++;
					if (want.bad_direction)
						bad_seen++;
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// File: sim/lattice_random_walk_absorber_tb.sv
// testbench top: stimulus, receiver stalls, watchdog and verdict for the random walk absorber
`timescale 1ns / 1ps
module lattice_random_walk_absorber_tb;
	import lrwa_pkg::*;

	localparam logic FN_STEP       = 1'b0;
	localparam logic FN_RESTART    = 1'b1;
	localparam int   RANDOM_ITEMS  = 1800;
	localparam int   HOLD_CYCLES   = 120;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   CYCLE_LIMIT   = 2000000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      func = FN_STEP;
	logic [DIR_W-1:0]          direction = '0;
	logic                      step_up = 1'b0;
	logic [FRAC_W-1:0]         random_fraction = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      caught;
	logic [STEPS_W-1:0]        step_count;
	logic [DIR_W-1:0]          moved_axis;
	logic signed [VALUE_W-1:0] moved_value;
	logic                      bad_direction;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	cfg_idx_t                  cfg_index = REG_DIMENSIONS;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	// figures handed up by the checker
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned results_checked;
	int unsigned captures_seen;
	int unsigned bad_seen;

	// stimulus bookkeeping
	logic              calm = 1'b0;
	logic              hold_req = 1'b0;
	logic [DIMS_W-1:0] dims_now = 4'd2;
	int unsigned       items_sent = 0;
	int unsigned       reg_writes = 0;
	int unsigned       phases = 0;
	int unsigned       cycle_count = 0;

	lattice_random_walk_absorber dut (.*);

	lattice_random_walk_absorber_check walk_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				outstanding);
			$display("lattice_random_walk_absorber verification failed");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 96)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// receiver: random stall bursts, and one long hold-off on request
	initial begin : receiver
		int unsigned burst;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				burst = calm ? 0 : pick_gap();
				if (burst != 0) begin
					out_stall <= 1'b1;
					repeat (burst) @(posedge clk);
				end
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// offer one item, after an optional gap, and wait for its transfer
	task automatic offer_item(input logic fn, input logic [DIR_W-1:0] dir, input logic up,
		input logic [FRAC_W-1:0] frac);
		int unsigned gap;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		direction <= dir;
		step_up <= up;
		random_fraction <= frac;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic take_step(input logic [DIR_W-1:0] dir, input logic up,
		input logic [FRAC_W-1:0] frac);
		offer_item(FN_STEP, dir, up, frac);
	endtask

	// restart with random don't-care fields
	task automatic restart_walker();
		offer_item(FN_RESTART, DIR_W'($urandom_range(7)), 1'($urandom_range(1)),
			FRAC_W'($urandom));
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == REG_DIMENSIONS)
			dims_now = value[DIMS_W-1:0];
	endtask

	initial begin
		int unsigned           axes;
		int unsigned           phase_len;
		logic [DIR_W-1:0]      dir;
		logic [FRAC_W-1:0]     frac;
		logic [CFG_DATA_W-1:0] pick_dims;
		logic [CFG_DATA_W-1:0] pick_bound;
		logic [CFG_DATA_W-1:0] pick_prob;
		logic [CFG_DATA_W-1:0] pick_max;
		mode_t                 pick_mode;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: two axes, chance mode
		take_step(0, 1, 16'd0);
		take_step(1, 0, 16'hFFFF);
		take_step(0, 1, 16'd6554);
		take_step(1, 1, 16'd6555);
		take_step(2, 1, FRAC_W'($urandom));
		take_step(7, 0, FRAC_W'($urandom));
		restart_walker();

		// probability at one, above one, and zero
		write_reg(REG_PROBABILITY, 32'd65536);
		take_step(0, 0, 16'hFFFF);
		write_reg(REG_PROBABILITY, 32'h1FFFF);
		take_step(1, 0, 16'hFFFF);
		write_reg(REG_PROBABILITY, 32'd0);
		take_step(0, 1, 16'd0);
		take_step(0, 1, 16'd1);

		// no axes at all, then more axes than the lattice has
		write_reg(REG_DIMENSIONS, 32'd0);
		take_step(0, 1, FRAC_W'($urandom));
		write_reg(REG_DIMENSIONS, 32'd15);
		take_step(7, 1, FRAC_W'($urandom));

		// square well of zero and of two
		write_reg(REG_WELL_MODE, CFG_DATA_W'(MODE_SQUARE));
		write_reg(REG_BOUNDARY, 32'd0);
		take_step(3, 1, FRAC_W'($urandom));
		write_reg(REG_BOUNDARY, 32'd2);
		take_step(3, 1, FRAC_W'($urandom));
		take_step(3, 0, FRAC_W'($urandom));

		// circular well over all eight axes
		write_reg(REG_WELL_MODE, CFG_DATA_W'(MODE_CIRCLE));
		take_step(4, 1, FRAC_W'($urandom));
		take_step(5, 0, FRAC_W'($urandom));
		take_step(4, 1, FRAC_W'($urandom));

		// step limit forces capture and it stays on for later steps
		write_reg(REG_WELL_MODE, CFG_DATA_W'(MODE_NEVER));
		write_reg(REG_MAX_STEPS, 32'd3);
		restart_walker();
		repeat (4) take_step(DIR_W'($urandom_range(7)), 1'($urandom_range(1)),
			FRAC_W'($urandom));
		write_reg(REG_MAX_STEPS, 32'hFFFF_FFFF);
		take_step(6, 0, FRAC_W'($urandom));

		// fewer axes without restart: upper axes keep values but are not tested
		write_reg(REG_DIMENSIONS, 32'd2);
		write_reg(REG_WELL_MODE, CFG_DATA_W'(MODE_SQUARE));
		write_reg(REG_BOUNDARY, 32'd1);
		take_step(1, 1, FRAC_W'($urandom));
		restart_walker();

		// random phases, each with its own settings
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(11))
				0:       pick_dims = 0;
				1, 2:    pick_dims = 1;
				3, 4:    pick_dims = 2;
				5, 6:    pick_dims = 8;
				7, 8, 9: pick_dims = $urandom_range(7, 3);
				default: pick_dims = $urandom_range(15, 9);
			endcase
			pick_mode = mode_t'($urandom_range(3));
			case ($urandom_range(9))
				0:       pick_bound = 0;
				1:       pick_bound = 32767;
				2:       pick_bound = $urandom_range(32767);
				default: pick_bound = $urandom_range(8, 1);
			endcase
			case ($urandom_range(7))
				0:       pick_prob = 0;
				1:       pick_prob = 65535;
				2:       pick_prob = 65536;
				3:       pick_prob = 32'h1FFFF;
				4:       pick_prob = $urandom_range(32'h1FFFF);
				default: pick_prob = $urandom_range(65536);
			endcase
			case ($urandom_range(7))
				0:       pick_max = $urandom_range(60, 1);
				1:       pick_max = 32'hFFFF_FFFF;
				2:       pick_max = $urandom;
				default: pick_max = 0;
			endcase
			write_reg(REG_DIMENSIONS, pick_dims);
			write_reg(REG_WELL_MODE, CFG_DATA_W'(pick_mode));
			write_reg(REG_BOUNDARY, pick_bound);
			write_reg(REG_PROBABILITY, pick_prob);
			write_reg(REG_MAX_STEPS, pick_max);
			axes = (dims_now > MAX_DIMS) ? MAX_DIMS : dims_now;

			// first phase: receiver holds off while items keep coming
			calm = (phases == 0) || ($urandom_range(4) == 0);
			if (phases == 0)
				hold_req = 1'b1;

			if ($urandom_range(1))
				restart_walker();
			phase_len = $urandom_range(320, 120);
			for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
				case ($urandom_range(9))
					0:       frac = '0;
					1:       frac = {FRAC_W{1'b1}};
					default: frac = FRAC_W'($urandom);
				endcase
				case ($urandom_range(99)) inside
					[0:2]: begin
						restart_walker();
					end
					[3:11]: begin
						// noise: any axis, often out of range
						dir = DIR_W'($urandom_range(7));
						take_step(dir, 1'($urandom_range(1)), frac);
					end
					default: begin
						dir = (axes == 0) ? DIR_W'($urandom_range(7))
							: DIR_W'($urandom_range(axes - 1));
						take_step(dir, 1'($urandom_range(1)), frac);
					end
				endcase
			end
			phases++;
		end

		calm = 1'b0;
		drain();
		$display("covered %0d items, %0d results checked: %0d captures, %0d bad directions",
			items_sent, results_checked, captures_seen, bad_seen);
		$display("directed corners plus %0d random setting phases, %0d register writes",
			phases, reg_writes);
		if (mismatches == 0)
			$display("lattice_random_walk_absorber verification clean");
		else
			$display("lattice_random_walk_absorber verification failed");
		$finish;
	end

endmodule
